// ----- rtl/core/step_axis_soft_limit_generator_macros.svh -----
// assertion macros shared by the step axis checker
`ifndef STEP_AXIS_SOFT_LIMIT_GENERATOR_MACROS_SVH
`define STEP_AXIS_SOFT_LIMIT_GENERATOR_MACROS_SVH

// same-cycle implication, checked on clk outside reset
`define SASL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on clk outside reset
`define SASL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/sasl_pkg.sv -----
// types and constants of the step axis soft limit generator
`default_nettype none

package sasl_pkg;

    // register indexes of the configuration port
    localparam int CFG_INDEX_BITS = 1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SOFT_MIN = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SOFT_MAX = 1'b1;

    // reset values of the soft limits
    localparam logic signed [31:0] SOFT_MIN_RESET = 32'sh8000_0000;
    localparam logic signed [31:0] SOFT_MAX_RESET = 32'sh7FFF_FFFF;

    // width of the rate field in an input beat
    localparam int RATE_FIELD_BITS = 20;

    // move direction encoding
    typedef enum logic [1:0] {
        DIR_STOP = 2'd0,
        DIR_FWD  = 2'd1,
        DIR_REV  = 2'd3
    } dir_t;

    // one timer tick
    typedef struct packed {
        logic                       set_enable;
        logic                       enable_value;
        logic                       set_direction;
        logic                       forward;
        logic                       set_rate;
        logic [RATE_FIELD_BITS-1:0] rate_period;
        logic                       zero_position;
        logic                       limit_level;
        logic                       debounce_check;
    } in_item_t;

    // result of one tick
    typedef struct packed {
        logic               step_pulse;
        logic               dir_level;
        logic               enable_n;
        logic signed [31:0] position;
        logic               at_soft_limit;
        logic               limit_latched;
        logic               genuine_closure;
        logic               running;
    } out_item_t;

    // axis state apart from the period counter
    typedef struct packed {
        logic signed [31:0] pos;
        dir_t               dir;
        logic               active;
        logic               flag;
        logic               last_level;
        logic               drv_en;
    } axis_state_t;

endpackage

`default_nettype wire

// ----- rtl/core/step_axis_soft_limit_generator.sv -----
// Step/direction generator for one stepper axis with soft position limits.
// Input channel (in_valid, in_stall, in_data): one beat per timer tick with the
// enable, direction, rate and zero strobes, the raw limit switch pin and the
// debounce strobe. Output channel (out_valid, out_stall, out_data): one beat per
// tick with the step pulse, pin levels, position and status flags.
// Config port (cfg_we, cfg_index, cfg_data): soft_min at index 0, soft_max at 1,
// to be written only while no beat is in flight; the block leaves this to the user.
// A tick accepted into the input register passes through the tick logic into the
// output register once the output side is free. Throughput is one tick per cycle
// while the receiver does not stall; the tick logic between the input and output
// registers is one 33-bit add and compare per beat.
// Reset clears the axis state (position zero, stopped, driver disabled, limit
// switch seen open, limits at the full signed range) and empties both stages.
// When the receiver stalls, the output beat holds; one more tick waits in the
// input register, and in_stall rises only when both are full.
`default_nettype none

module step_axis_soft_limit_generator #(
    parameter int PERIOD_BITS = 20
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  sasl_pkg::in_item_t                    in_data,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output sasl_pkg::out_item_t                   out_data,
    input  logic                                  cfg_we,
    input  logic [sasl_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [31:0]                           cfg_data
);
    import sasl_pkg::*;

    logic                   in_valid_reg;
    in_item_t               in_item_reg;
    logic                   out_valid_reg;
    out_item_t              out_item_reg;
    axis_state_t            state_reg;
    axis_state_t            state_next;
    logic [PERIOD_BITS-1:0] count_reg;
    logic [PERIOD_BITS-1:0] count_next;
    logic [PERIOD_BITS-1:0] reload_reg;
    logic [PERIOD_BITS-1:0] reload_next;
    logic signed [31:0]     soft_min_reg;
    logic signed [31:0]     soft_max_reg;
    out_item_t              result;
    logic                   out_free;
    logic                   advance;
    logic                   in_take;

    // pipeline flow
    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = in_valid_reg && out_free;
    assign in_stall = in_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    // soft limit registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            soft_min_reg <= SOFT_MIN_RESET;
            soft_max_reg <= SOFT_MAX_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SOFT_MIN: soft_min_reg <= cfg_data;
                REG_SOFT_MAX: soft_max_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_item_reg <= in_data;
        end
    end

    // tick logic
    sasl_tick #(
        .PERIOD_BITS (PERIOD_BITS)
    ) u_tick (
        .item        (in_item_reg),
        .cur         (state_reg),
        .count       (count_reg),
        .reload      (reload_reg),
        .soft_min    (soft_min_reg),
        .soft_max    (soft_max_reg),
        .nxt         (state_next),
        .count_next  (count_next),
        .reload_next (reload_next),
        .result      (result)
    );

    // axis state, updated once per processed tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= '{pos: '0, dir: DIR_STOP, active: 1'b0, flag: 1'b0,
                           last_level: 1'b1, drv_en: 1'b0};
            count_reg  <= '0;
            reload_reg <= '0;
        end
        else if (advance)
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            reload_reg <= reload_next;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_item_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

endmodule

`default_nettype wire

// ----- rtl/core/sasl_tick.sv -----
// next-state and result logic for one timer tick
`default_nettype none

module sasl_tick #(
    parameter int PERIOD_BITS = 20
) (
    input  sasl_pkg::in_item_t    item,
    input  sasl_pkg::axis_state_t cur,
    input  logic [PERIOD_BITS-1:0] count,
    input  logic [PERIOD_BITS-1:0] reload,
    input  logic signed [31:0]    soft_min,
    input  logic signed [31:0]    soft_max,
    output sasl_pkg::axis_state_t nxt,
    output logic [PERIOD_BITS-1:0] count_next,
    output logic [PERIOD_BITS-1:0] reload_next,
    output sasl_pkg::out_item_t   result
);
    import sasl_pkg::*;

    localparam int RATE_BITS = (PERIOD_BITS < RATE_FIELD_BITS) ? PERIOD_BITS
                                                               : RATE_FIELD_BITS;

    logic [PERIOD_BITS-1:0] rate;
    logic                   loaded;
    logic                   genuine;
    logic                   pulse;
    logic signed [32:0]     pos_step;
    logic signed [32:0]     min_ext;
    logic signed [32:0]     max_ext;

    // rate field limited to the counter width
    assign rate = PERIOD_BITS'(item.rate_period[RATE_BITS-1:0]);

    // limits one bit wider for the step compare
    assign min_ext  = {soft_min[31], soft_min};
    assign max_ext  = {soft_max[31], soft_max};

    // commands, limit switch and period counter in tick order
    always_comb
    begin
        nxt         = cur;
        count_next  = count;
        reload_next = reload;
        loaded      = 1'b0;
        genuine     = 1'b0;
        pulse       = 1'b0;

        if (item.set_enable)
        begin
            nxt.drv_en = item.enable_value;
            if (!item.enable_value)
            begin
                nxt.active = 1'b0;
                nxt.dir    = DIR_STOP;
            end
        end

        if (item.set_direction)
        begin
            nxt.dir = item.forward ? DIR_FWD : DIR_REV;
        end

        if (item.set_rate)
        begin
            if (rate == '0)
            begin
                nxt.active = 1'b0;
            end
            else
            begin
                nxt.active  = 1'b1;
                reload_next = rate;
                count_next  = rate;
                loaded      = 1'b1;
            end
        end

        if (item.zero_position)
        begin
            nxt.pos = '0;
        end

        // falling edge on the switch latches the flag and halts the timer
        if (cur.last_level && !item.limit_level)
        begin
            nxt.flag   = 1'b1;
            nxt.active = 1'b0;
        end
        nxt.last_level = item.limit_level;

        // debounce check: release if open, report if still closed
        if (item.debounce_check && nxt.flag)
        begin
            if (item.limit_level)
            begin
                nxt.flag = 1'b0;
            end
            else
            begin
                genuine = 1'b1;
            end
        end

        // candidate position one step away, one bit wider so it cannot wrap
        pos_step = $signed({nxt.pos[31], nxt.pos})
                 + ((nxt.dir == DIR_FWD) ? 33'sd1 : -33'sd1);

        // period counter, a step only inside the soft limits
        if (nxt.active && !loaded)
        begin
            count_next = count - PERIOD_BITS'(1);
            if (count_next == '0)
            begin
                count_next = reload;
                if (nxt.dir != DIR_STOP)
                begin
                    if ((pos_step < min_ext) || (pos_step > max_ext))
                    begin
                        nxt.active = 1'b0;
                        nxt.dir    = DIR_STOP;
                    end
                    else
                    begin
                        nxt.pos = pos_step[31:0];
                        pulse   = 1'b1;
                    end
                end
            end
        end
    end

    // result fields
    always_comb
    begin
        result.step_pulse      = pulse;
        result.dir_level       = (nxt.dir == DIR_FWD);
        result.enable_n        = !nxt.drv_en;
        result.position        = nxt.pos;
        result.at_soft_limit   = (nxt.pos <= soft_min) || (nxt.pos >= soft_max);
        result.limit_latched   = nxt.flag;
        result.genuine_closure = genuine;
        result.running         = nxt.active;
    end

endmodule

`default_nettype wire

// ----- rtl/core/sasl_checker.sv -----
// port-level checks for the step axis generator, bound to the top level
`default_nettype none

`include "step_axis_soft_limit_generator_macros.svh"

module sasl_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_stall,
    input logic                out_valid,
    input logic                out_stall,
    input sasl_pkg::out_item_t out_data
);

    // a stalled result beat stays and holds its payload
    `SASL_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "output beat changed while stalled")

    // input side backs up only when the output side is full and stalled
    `SASL_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall, "input stalled without a blocked output beat")

    // a step is only issued while the period counter runs
    `SASL_ASSERT_NOW(a_step_running, out_valid && out_data.step_pulse, out_data.running, "step pulse with the timer stopped")

    // a genuine closure leaves the limit flag set
    `SASL_ASSERT_NOW(a_closure_flag, out_valid && out_data.genuine_closure, out_data.limit_latched, "genuine closure with the limit flag clear")

endmodule

bind step_axis_soft_limit_generator sasl_checker u_sasl_checker (.*);

`default_nettype wire

// ----- sim/tb_step_axis_soft_limit_generator.sv -----
// self-checking testbench for the step axis soft limit generator
module tb_step_axis_soft_limit_generator;

    import sasl_pkg::*;

    localparam int PERIOD_BITS = 20;
    localparam int MAX_PRINTED = 50;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    in_item_t in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    out_item_t out_data;
    logic cfg_we = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    // ticks waiting to be sent and results waiting to arrive
    in_item_t tick_queue[$];
    out_item_t result_queue[$];

    // predicted axis state and limits
    logic signed [31:0] axis_pos;
    dir_t axis_dir;
    logic timer_on;
    logic [PERIOD_BITS-1:0] count_left;
    logic [PERIOD_BITS-1:0] count_reload;
    logic limit_hold;
    logic prev_level;
    logic driver_on;
    logic signed [31:0] min_limit;
    logic signed [31:0] max_limit;

    // stimulus and handshake bookkeeping
    logic switch_closed = 1'b0;
    int tx_wait = 0;
    int tx_calm = 0;
    logic tx_free;
    int rx_wait = 0;
    int rx_calm = 0;
    int beat_count = 0;
    int error_count = 0;

    step_axis_soft_limit_generator #(
        .PERIOD_BITS(PERIOD_BITS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // one line per failure, printing capped
    task automatic report_error(input string msg);
        if (error_count < MAX_PRINTED)
        begin
            $display("ERROR at %0t: %s", $time, msg);
        end
        error_count++;
    endtask

    // random wait per beat, with calm stretches of no waiting
    function automatic int draw_wait(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 29) == 0)
        begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        return $urandom_range(0, 15);
    endfunction

    // axis behavior for one tick: commands, limit switch, debounce, period counter
    function automatic out_item_t predict_tick(input in_item_t t);
        out_item_t r;
        logic pulse;
        logic genuine;
        logic loaded;
        logic signed [32:0] nxt;
        pulse = 1'b0;
        genuine = 1'b0;
        loaded = 1'b0;
        if (t.set_enable)
        begin
            driver_on = t.enable_value;
            if (!t.enable_value)
            begin
                timer_on = 1'b0;
                axis_dir = DIR_STOP;
            end
        end
        if (t.set_direction)
        begin
            axis_dir = t.forward ? DIR_FWD : DIR_REV;
        end
        if (t.set_rate)
        begin
            if (t.rate_period[PERIOD_BITS-1:0] == '0)
            begin
                timer_on = 1'b0;
            end
            else
            begin
                timer_on = 1'b1;
                count_reload = t.rate_period[PERIOD_BITS-1:0];
                count_left = t.rate_period[PERIOD_BITS-1:0];
                loaded = 1'b1;
            end
        end
        if (t.zero_position)
        begin
            axis_pos = '0;
        end
        // falling edge on the switch latches the flag and stops the counter
        if (prev_level && !t.limit_level)
        begin
            limit_hold = 1'b1;
            timer_on = 1'b0;
        end
        prev_level = t.limit_level;
        if (t.debounce_check && limit_hold)
        begin
            if (t.limit_level)
            begin
                limit_hold = 1'b0;
            end
            else
            begin
                genuine = 1'b1;
            end
        end
        // period elapse, step only if the next position stays in range
        if (timer_on && !loaded)
        begin
            count_left = count_left - 1'b1;
            if (count_left == '0)
            begin
                count_left = count_reload;
                if (axis_dir != DIR_STOP)
                begin
                    nxt = axis_pos;
                    nxt = (axis_dir == DIR_FWD) ? nxt + 33'sd1 : nxt - 33'sd1;
                    if (nxt < min_limit || nxt > max_limit)
                    begin
                        timer_on = 1'b0;
                        axis_dir = DIR_STOP;
                    end
                    else
                    begin
                        axis_pos = nxt[31:0];
                        pulse = 1'b1;
                    end
                end
            end
        end
        r.step_pulse = pulse;
        r.dir_level = (axis_dir == DIR_FWD);
        r.enable_n = !driver_on;
        r.position = axis_pos;
        r.at_soft_limit = (axis_pos <= min_limit) || (axis_pos >= max_limit);
        r.limit_latched = limit_hold;
        r.genuine_closure = genuine;
        r.running = timer_on;
        return r;
    endfunction

    // field by field comparison of one result beat
    task automatic check_result(input out_item_t got, input out_item_t exp);
        if (got.step_pulse !== exp.step_pulse)
            report_error($sformatf("beat %0d step_pulse %b, expected %b",
                beat_count, got.step_pulse, exp.step_pulse));
        if (got.dir_level !== exp.dir_level)
            report_error($sformatf("beat %0d dir_level %b, expected %b",
                beat_count, got.dir_level, exp.dir_level));
        if (got.enable_n !== exp.enable_n)
            report_error($sformatf("beat %0d enable_n %b, expected %b",
                beat_count, got.enable_n, exp.enable_n));
        if (got.position !== exp.position)
            report_error($sformatf("beat %0d position %0d, expected %0d",
                beat_count, got.position, exp.position));
        if (got.at_soft_limit !== exp.at_soft_limit)
            report_error($sformatf("beat %0d at_soft_limit %b, expected %b",
                beat_count, got.at_soft_limit, exp.at_soft_limit));
        if (got.limit_latched !== exp.limit_latched)
            report_error($sformatf("beat %0d limit_latched %b, expected %b",
                beat_count, got.limit_latched, exp.limit_latched));
        if (got.genuine_closure !== exp.genuine_closure)
            report_error($sformatf("beat %0d genuine_closure %b, expected %b",
                beat_count, got.genuine_closure, exp.genuine_closure));
        if (got.running !== exp.running)
            report_error($sformatf("beat %0d running %b, expected %b",
                beat_count, got.running, exp.running));
    endtask

    // input beat builder
    function automatic in_item_t tick(input logic se, input logic ev, input logic sd,
                                      input logic fw, input logic sr,
                                      input logic [RATE_FIELD_BITS-1:0] rate,
                                      input logic zp, input logic lvl, input logic dc);
        in_item_t t;
        t.set_enable = se;
        t.enable_value = ev;
        t.set_direction = sd;
        t.forward = fw;
        t.set_rate = sr;
        t.rate_period = rate;
        t.zero_position = zp;
        t.limit_level = lvl;
        t.debounce_check = dc;
        return t;
    endfunction

    // random tick: mostly a running axis with sparse commands, some pure noise
    function automatic in_item_t random_tick();
        in_item_t t;
        logic [31:0] bits;
        int r;
        bits = $urandom;
        t = bits[$bits(in_item_t)-1:0];
        if ($urandom_range(0, 99) < 8)
        begin
            return t;
        end
        t.set_enable = ($urandom_range(0, 99) < 3);
        t.enable_value = ($urandom_range(0, 3) != 0);
        t.set_direction = ($urandom_range(0, 99) < 6);
        t.set_rate = ($urandom_range(0, 99) < 5);
        if (t.set_rate)
        begin
            r = $urandom_range(0, 19);
            if (r == 0)
                t.rate_period = '0;
            else if (r != 1)
                t.rate_period = RATE_FIELD_BITS'($urandom_range(1, 6));
        end
        t.zero_position = ($urandom_range(0, 99) < 2);
        // switch stays closed or open for stretches
        if ($urandom_range(0, 99) < 3)
        begin
            switch_closed = !switch_closed;
        end
        t.limit_level = !switch_closed;
        t.debounce_check = ($urandom_range(0, 99) < 6);
        return t;
    endfunction

    // register write on the config port
    task automatic write_limit(input logic [CFG_INDEX_BITS-1:0] idx,
                               input logic signed [31:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        if (idx == REG_SOFT_MIN)
            min_limit = val;
        else
            max_limit = val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // block is idle once every tick is sent and every result is back
    task automatic wait_drained();
        while (tick_queue.size() != 0 || in_valid || result_queue.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    // one setting of the soft limits followed by random ticks
    task automatic run_phase(input logic signed [31:0] lo, input logic signed [31:0] hi,
                             input int count);
        write_limit(REG_SOFT_MIN, lo);
        write_limit(REG_SOFT_MAX, hi);
        @(negedge clk);
        repeat (count)
        begin
            tick_queue.push_back(random_tick());
        end
        wait_drained();
    endtask

    // driver: present queued ticks, predict each accepted beat
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data <= '0;
            tx_wait = 0;
        end
        else
        begin
            tx_free = !in_valid || !in_stall;
            if (in_valid && !in_stall)
            begin
                result_queue.push_back(predict_tick(in_data));
                tx_wait = draw_wait(tx_calm);
            end
            if (tx_free)
            begin
                if (tx_wait > 0)
                begin
                    tx_wait--;
                    in_valid <= 1'b0;
                end
                else if (tick_queue.size() != 0)
                begin
                    in_data <= tick_queue.pop_front();
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: check each accepted result beat, stall at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            rx_wait = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                beat_count++;
                if (result_queue.size() == 0)
                    report_error($sformatf("beat %0d arrived with no tick pending",
                        beat_count));
                else
                    check_result(out_data, result_queue.pop_front());
                rx_wait = draw_wait(rx_calm);
            end
            else if (rx_wait > 0)
            begin
                rx_wait--;
            end
            out_stall <= (rx_wait > 0);
        end
    end

    // main sequence
    initial
    begin
        axis_pos = '0;
        axis_dir = DIR_STOP;
        timer_on = 1'b0;
        count_left = '0;
        count_reload = '0;
        limit_hold = 1'b0;
        prev_level = 1'b1;
        driver_on = 1'b0;
        min_limit = SOFT_MIN_RESET;
        max_limit = SOFT_MAX_RESET;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed ticks at reset limits
        tick_queue.push_back(tick(0, 0, 0, 0, 0, '0, 0, 1, 0));
        tick_queue.push_back(tick(1, 1, 0, 0, 0, '0, 0, 1, 0));
        // forward at one tick per step
        tick_queue.push_back(tick(0, 0, 1, 1, 1, 1, 0, 1, 0));
        repeat (3) tick_queue.push_back(tick(0, 0, 0, 0, 0, '0, 0, 1, 0));
        // reload with a longer period
        tick_queue.push_back(tick(0, 0, 0, 0, 1, 3, 0, 1, 0));
        repeat (3) tick_queue.push_back(tick(0, 0, 0, 0, 0, '0, 0, 1, 0));
        // reverse with zero period stops but keeps direction
        tick_queue.push_back(tick(0, 0, 1, 0, 1, '0, 0, 1, 0));
        tick_queue.push_back(tick(0, 0, 0, 0, 1, 2, 0, 1, 0));
        repeat (2) tick_queue.push_back(tick(0, 0, 0, 0, 0, '0, 0, 1, 0));
        // switch closes, genuine closure with restart while latched, then release
        tick_queue.push_back(tick(0, 0, 0, 0, 0, '0, 0, 0, 0));
        tick_queue.push_back(tick(0, 0, 0, 0, 1, 1, 0, 0, 1));
        tick_queue.push_back(tick(0, 0, 0, 0, 0, '0, 0, 1, 1));
        // enable, direction and rate commands at once with the largest period, then zero
        tick_queue.push_back(tick(1, 0, 1, 1, 1, '1, 0, 1, 0));
        tick_queue.push_back(tick(0, 0, 0, 0, 0, '0, 1, 1, 0));
        // disabled axis, period elapses with no direction, then steps while disabled
        tick_queue.push_back(tick(1, 0, 0, 0, 0, '0, 0, 1, 0));
        tick_queue.push_back(tick(0, 0, 0, 0, 1, 1, 0, 1, 0));
        tick_queue.push_back(tick(0, 0, 0, 0, 0, '0, 0, 1, 0));
        tick_queue.push_back(tick(0, 0, 1, 1, 0, '0, 0, 1, 0));
        tick_queue.push_back(tick(0, 0, 0, 0, 0, '0, 0, 1, 0));
        wait_drained();

        // random ticks across limit settings, extremes and inverted ranges included
        run_phase(SOFT_MIN_RESET, SOFT_MAX_RESET, 220);
        run_phase(-32'sd8, 32'sd8, 220);
        run_phase(32'sd0, 32'sd0, 150);
        run_phase(32'sd3, -32'sd3, 150);
        run_phase(SOFT_MAX_RESET, SOFT_MIN_RESET, 150);
        run_phase(-32'sd1000, 32'sd5, 220);
        run_phase(-32'sd3, 32'sd100, 220);
        repeat (2)
        begin
            run_phase(-$signed(32'($urandom_range(0, 30))), 32'($urandom_range(0, 30)), 210);
        end

        // let any stray beat show up
        repeat (8) @(posedge clk);
        if (result_queue.size() != 0)
            report_error($sformatf("%0d results never arrived", result_queue.size()));
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // watchdog
    initial
    begin
        #5000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/sasl_pkg.sv
rtl/core/sasl_tick.sv
rtl/core/step_axis_soft_limit_generator.sv
rtl/core/sasl_checker.sv
sim/tb_step_axis_soft_limit_generator.sv
